// ===== sv/swarq_pkg.sv =====
// ----------------------------------------------------------------------------
// swarq_pkg
// Types and constants shared by the sliding-window ARQ sender.
// ----------------------------------------------------------------------------
package swarq_pkg;

    localparam int WINDOW_SLOTS = 8;
    localparam int SEQ_COUNT    = 16;
    localparam int RECEIVERS    = 4;

    localparam int SLOT_W = 3;
    localparam int SEQ_W  = 4;
    localparam int RCV_W  = 2;
    localparam int TMR_W  = 16;
    localparam int ADDR_W = RCV_W + SLOT_W;
    localparam int CFG_W  = 16;
    localparam int LIM_W  = 3;

    localparam logic [TMR_W-1:0] DEFAULT_TIMEOUT = 16'd100;
    localparam logic [LIM_W-1:0] DEFAULT_ACTIVE  = 3'd4;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_NAK  = 2'd2,
        CMD_TICK = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        KIND_NEW    = 2'd0,
        KIND_RETX   = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REG_SENDER_ID = 2'd0,
        REG_ACTIVE    = 2'd1,
        REG_TIMEOUT   = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_EVAL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]       command;
        logic [RCV_W-1:0] receiver;
        logic [7:0]       frame_dest;
        logic [SEQ_W-1:0] ack_number;
        logic             crc_ok;
    } t_in;

    typedef struct packed {
        logic [1:0]        kind;
        logic [RCV_W-1:0]  dest_receiver;
        logic [SEQ_W-1:0]  seq_num;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_out;

    typedef struct packed {
        logic load;
        logic start;
        logic next_rcv;
        logic rd;
        logic step;
        logic flush;
    } t_ctl;

    typedef struct packed {
        logic is_send;
        logic walk_ok;
        logic walk_end;
        logic rcv_last;
        logic ack_done;
        logic emit_req;
        logic can_emit;
        logic pend_v;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/sliding_window_arq_sender.sv =====
// ----------------------------------------------------------------------------
// sliding_window_arq_sender
// Go-back-N send windows for several receivers: sequencer plus slot datapath.
// ----------------------------------------------------------------------------
//  channel  | signals                              | moves
//  ---------+--------------------------------------+------------------------
//  in       | i_in_valid / o_in_ready / i_in_data  | one command item
//  out      | o_out_valid / i_out_ready / o_out_data | one result item
//  cfg      | i_cfg_we / i_cfg_idx / i_cfg_data     | register write
//
// A send, or an ack/nak that is dropped, goes from start straight to the
// final state. Ack and nak walk occupied slots through the slot store, each
// slot read, then evaluated; an ack that hits ends the walk. A tick walks the
// occupied slots of every active receiver in turn.
// Reset (synchronous, active low) clears pointers; the slot store is not reset.
// A stalled output holds the walk when a further result is due.
// ----------------------------------------------------------------------------
module sliding_window_arq_sender (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  swarq_pkg::t_in               i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output swarq_pkg::t_out              o_out_data,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [swarq_pkg::CFG_W-1:0]  i_cfg_data
);

    logic [7:0]                  r_sender_id;
    logic [swarq_pkg::LIM_W-1:0] r_active;
    logic [swarq_pkg::TMR_W-1:0] r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sender_id <= '0;
            r_active    <= swarq_pkg::DEFAULT_ACTIVE;
            r_timeout   <= swarq_pkg::DEFAULT_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swarq_pkg::REG_SENDER_ID: r_sender_id <= i_cfg_data[7:0];
                swarq_pkg::REG_ACTIVE:    r_active    <= i_cfg_data[swarq_pkg::LIM_W-1:0];
                swarq_pkg::REG_TIMEOUT:   r_timeout   <= i_cfg_data[swarq_pkg::TMR_W-1:0];
                default: ;
            endcase
        end
    end

    swarq_pkg::t_ctl   w_ctl;
    swarq_pkg::t_sts   w_sts;
    swarq_pkg::t_state w_state;

    swarq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_ctl      (w_ctl),
        .o_state    (w_state)
    );

    swarq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_in_data   (i_in_data),
        .i_sender_id (r_sender_id),
        .i_active    (r_active),
        .i_timeout   (r_timeout),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // nothing may be held back once the sequencer is idle
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == swarq_pkg::ST_IDLE) |-> !w_sts.pend_v)
        else $error("pending result left at idle");

    // the walk only steps past a due result when the pending stage can take it
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.step && w_sts.emit_req) |-> w_sts.can_emit)
        else $error("result step without room");

    // a flush only happens from the final state with something to send
    a_flush_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.flush |-> (w_state == swarq_pkg::ST_FIN) && w_sts.pend_v)
        else $error("flush outside final state");

    // the output never carries an undefined kind
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.kind == swarq_pkg::KIND_NEW
                         || o_out_data.kind == swarq_pkg::KIND_RETX
                         || o_out_data.kind == swarq_pkg::KIND_REJECT))
        else $error("illegal result kind");

endmodule

// ===== sv/swarq_ctrl.sv =====
// ----------------------------------------------------------------------------
// swarq_ctrl
// Sequencer: decodes an item, walks window slots one at a time, drains result.
// ----------------------------------------------------------------------------
module swarq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  swarq_pkg::t_sts    i_sts,
    output logic               o_in_ready,
    output swarq_pkg::t_ctl    o_ctl,
    output swarq_pkg::t_state  o_state
);

    swarq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swarq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            swarq_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = swarq_pkg::ST_START;
            end
            swarq_pkg::ST_START: begin
                if (i_sts.is_send || !i_sts.walk_ok) n_state = swarq_pkg::ST_FIN;
                else n_state = swarq_pkg::ST_READ;
            end
            swarq_pkg::ST_READ: begin
                if (!i_sts.walk_end) n_state = swarq_pkg::ST_EVAL;
                else if (i_sts.rcv_last) n_state = swarq_pkg::ST_FIN;
            end
            swarq_pkg::ST_EVAL: begin
                if (!i_sts.emit_req || i_sts.can_emit) begin
                    n_state = i_sts.ack_done ? swarq_pkg::ST_FIN : swarq_pkg::ST_READ;
                end
            end
            swarq_pkg::ST_FIN: begin
                if (!i_sts.pend_v || i_sts.out_free) n_state = swarq_pkg::ST_IDLE;
            end
            default: n_state = swarq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            swarq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            swarq_pkg::ST_START: begin
                o_ctl.start = 1'b1;
            end
            swarq_pkg::ST_READ: begin
                o_ctl.rd       = !i_sts.walk_end;
                o_ctl.next_rcv = i_sts.walk_end && !i_sts.rcv_last;
            end
            swarq_pkg::ST_EVAL: begin
                o_ctl.step = !i_sts.emit_req || i_sts.can_emit;
            end
            swarq_pkg::ST_FIN: begin
                o_ctl.flush = i_sts.pend_v && i_sts.out_free;
            end
            default: ;
        endcase
    end

    assign o_state = r_state;

endmodule

// ===== sv/swarq_dp.sv =====
// ----------------------------------------------------------------------------
// swarq_dp
// Window pointers, slot store, pending result and output register.
// ----------------------------------------------------------------------------
module swarq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swarq_pkg::t_ctl               i_ctl,
    input  swarq_pkg::t_in                i_in_data,
    input  logic [7:0]                    i_sender_id,
    input  logic [swarq_pkg::LIM_W-1:0]   i_active,
    input  logic [swarq_pkg::TMR_W-1:0]   i_timeout,
    input  logic                          i_out_ready,
    output swarq_pkg::t_sts               o_sts,
    output logic                          o_out_valid,
    output swarq_pkg::t_out               o_out_data
);

    localparam int SW = swarq_pkg::SLOT_W;
    localparam int QW = swarq_pkg::SEQ_W;
    localparam int RW = swarq_pkg::RCV_W;
    localparam int TW = swarq_pkg::TMR_W;
    localparam int AW = swarq_pkg::ADDR_W;
    localparam int LW = swarq_pkg::LIM_W;
    localparam int DEPTH = swarq_pkg::RECEIVERS * swarq_pkg::WINDOW_SLOTS;
    localparam logic [LW-1:0] NRCV = LW'(swarq_pkg::RECEIVERS);

    // per-receiver pointers
    logic [SW-1:0] r_oldest [swarq_pkg::RECEIVERS];
    logic [SW-1:0] r_nfree  [swarq_pkg::RECEIVERS];
    logic [QW-1:0] r_nseq   [swarq_pkg::RECEIVERS];

    // slot store: {sequence, timer}
    logic [QW+TW-1:0] r_mem [DEPTH];
    logic [QW+TW-1:0] r_rd;

    swarq_pkg::t_in r_item;
    logic [RW-1:0]  r_rcv;
    logic [SW-1:0]  r_ptr;
    logic           r_hit;
    logic           r_pend_v;
    swarq_pkg::t_out r_pend;
    logic           r_out_v;
    swarq_pkg::t_out r_out;

    logic [LW-1:0] w_limit;
    logic          w_is_tick, w_is_ack, w_is_nak, w_rcv_ok, w_ok_frame;
    logic          w_full, w_match, w_expired, w_emit, w_out_free, w_can_emit;
    logic [QW-1:0] w_rd_seq;
    logic [TW-1:0] w_rd_tmr;
    logic [RW-1:0] w_rcv_nxt;
    logic [LW-1:0] w_rcv_inc;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [QW+TW-1:0] w_wdata;
    swarq_pkg::t_out w_new;

    assign w_limit    = (i_active > NRCV) ? NRCV : i_active;
    assign w_is_tick  = r_item.command == swarq_pkg::CMD_TICK;
    assign w_is_ack   = r_item.command == swarq_pkg::CMD_ACK;
    assign w_is_nak   = r_item.command == swarq_pkg::CMD_NAK;
    assign w_rcv_ok   = {1'b0, r_item.receiver} < NRCV;
    assign w_ok_frame = r_item.crc_ok && (r_item.frame_dest == i_sender_id) && w_rcv_ok;
    assign w_full     = !w_rcv_ok || (SW'(r_nfree[r_item.receiver] + 1'b1)
                                      == r_oldest[r_item.receiver]);
    assign w_rd_seq   = r_rd[QW+TW-1:TW];
    assign w_rd_tmr   = r_rd[TW-1:0];
    assign w_match    = w_rd_seq == r_item.ack_number;
    assign w_expired  = w_rd_tmr <= TW'(1);
    assign w_emit     = (w_is_nak && (w_match || r_hit)) || (w_is_tick && w_expired);
    assign w_out_free = !r_out_v || i_out_ready;
    assign w_can_emit = !r_pend_v || w_out_free;
    assign w_rcv_inc  = LW'({1'b0, r_rcv}) + 1'b1;
    assign w_rcv_nxt  = RW'(w_rcv_inc);

    assign o_sts.is_send  = r_item.command == swarq_pkg::CMD_SEND;
    assign o_sts.walk_ok  = w_is_tick ? (w_limit != '0) : w_ok_frame;
    assign o_sts.walk_end = r_ptr == r_nfree[r_rcv];
    assign o_sts.rcv_last = !w_is_tick || (w_rcv_inc >= w_limit);
    assign o_sts.ack_done = w_is_ack && w_match;
    assign o_sts.emit_req = w_emit;
    assign o_sts.can_emit = w_can_emit;
    assign o_sts.pend_v   = r_pend_v;
    assign o_sts.out_free = w_out_free;

    // result produced this cycle, if any
    always_comb begin
        w_new = '0;
        w_new.dest_receiver = r_rcv;
        if (i_ctl.start) begin
            w_new.dest_receiver = r_item.receiver;
            if (w_full) begin
                w_new.kind = swarq_pkg::KIND_REJECT;
            end else begin
                w_new.kind    = swarq_pkg::KIND_NEW;
                w_new.seq_num = r_nseq[r_item.receiver];
                w_new.slot    = r_nfree[r_item.receiver];
            end
        end else begin
            w_new.kind    = swarq_pkg::KIND_RETX;
            w_new.seq_num = w_rd_seq;
            w_new.slot    = r_ptr;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_rcv, r_ptr};
        w_wdata = {w_rd_seq, w_expired ? i_timeout : TW'(w_rd_tmr - 1'b1)};
        if (i_ctl.start && o_sts.is_send && !w_full) begin
            w_we    = 1'b1;
            w_waddr = {r_item.receiver, r_nfree[r_item.receiver]};
            w_wdata = {r_nseq[r_item.receiver], i_timeout};
        end else if (i_ctl.step && w_is_tick) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (i_ctl.rd) r_rd <= r_mem[{r_rcv, r_ptr}];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) r_item <= i_in_data;
        if (i_ctl.start) begin
            r_hit <= 1'b0;
            if (w_is_tick) begin
                r_rcv <= '0;
                r_ptr <= r_oldest[0];
            end else begin
                r_rcv <= r_item.receiver;
                r_ptr <= r_oldest[r_item.receiver];
            end
        end
        if (i_ctl.next_rcv) begin
            r_rcv <= w_rcv_nxt;
            r_ptr <= r_oldest[w_rcv_nxt];
        end
        if (i_ctl.step) begin
            r_ptr <= SW'(r_ptr + 1'b1);
            if (w_is_nak && w_match) r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < swarq_pkg::RECEIVERS; i++) begin
                r_oldest[i] <= '0;
                r_nfree[i]  <= '0;
                r_nseq[i]   <= '0;
            end
        end else begin
            if (i_ctl.start && o_sts.is_send && !w_full) begin
                r_nfree[r_item.receiver] <= SW'(r_nfree[r_item.receiver] + 1'b1);
                r_nseq[r_item.receiver]  <= QW'(r_nseq[r_item.receiver] + 1'b1);
            end
            if (i_ctl.step && w_is_ack && w_match) begin
                r_oldest[r_rcv] <= SW'(r_ptr + 1'b1);
            end
        end
    end

    // one result is held back until the next one shows whether it is last
    logic w_take_new, w_push;
    assign w_take_new = (i_ctl.start && o_sts.is_send) || (i_ctl.step && w_emit);
    assign w_push     = (w_take_new && r_pend_v) || i_ctl.flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_take_new) r_pend_v <= 1'b1;
            else if (i_ctl.flush) r_pend_v <= 1'b0;
            if (w_push) r_out_v <= 1'b1;
            else if (i_out_ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_new) r_pend <= w_new;
        if (w_push) begin
            r_out      <= r_pend;
            r_out.last <= i_ctl.flush;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

// ===== bench/sliding_window_arq_sender_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_arq_sender_tb
// Self-checking bench: a table of directed items, then random send/ack/nak/
// tick traffic over several register settings. It tracks the send windows on
// its own and compares every result item with the oldest expected one.
// ----------------------------------------------------------------------------
module sliding_window_arq_sender_tb;

    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 2000;
    localparam int N_DIRECTED    = 17;
    localparam int N_RANDOM      = 100;
    localparam int IN_W          = $bits(swarq_pkg::t_in);
    localparam int CFG_W         = swarq_pkg::CFG_W;
    localparam int LIM_W         = swarq_pkg::LIM_W;
    localparam int TMR_W         = swarq_pkg::TMR_W;
    localparam int SLOT_W        = swarq_pkg::SLOT_W;
    localparam int SEQ_W         = swarq_pkg::SEQ_W;
    localparam int RCV_W         = swarq_pkg::RCV_W;
    localparam int RECEIVERS     = swarq_pkg::RECEIVERS;
    localparam int WINDOW_SLOTS  = swarq_pkg::WINDOW_SLOTS;

    typedef struct packed {
        swarq_pkg::t_in  item;
        logic            typed;
        swarq_pkg::t_out result;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_ready;
    swarq_pkg::t_in       in_data;
    logic                 out_valid;
    logic                 out_ready;
    swarq_pkg::t_out      out_data;
    logic                 cfg_we;
    logic [1:0]           cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    // bench copy of the windows and registers
    logic [7:0]           id_reg;
    logic [LIM_W-1:0]     active_reg;
    logic [TMR_W-1:0]     timeout_reg;
    logic [SLOT_W-1:0]    oldest     [RECEIVERS];
    logic [SLOT_W-1:0]    free_slot  [RECEIVERS];
    logic [SEQ_W-1:0]     next_seq   [RECEIVERS];
    logic [SEQ_W-1:0]     slot_seq   [RECEIVERS][WINDOW_SLOTS];
    logic [TMR_W-1:0]     slot_tmr   [RECEIVERS][WINDOW_SLOTS];

    swarq_pkg::t_out      frames_due [$];
    t_dir_row             dir_rows   [N_DIRECTED];
    int                   idle_pct;
    int                   mismatches;
    int                   items_sent;
    int                   results_seen;
    int                   retx_seen;
    int                   stall_cnt;

    sliding_window_arq_sender i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_frame(logic [1:0] kind, logic [RCV_W-1:0] r,
                                       logic [SEQ_W-1:0] seq, logic [SLOT_W-1:0] s);
        swarq_pkg::t_out f;
        f.kind          = kind;
        f.dest_receiver = r;
        f.seq_num       = seq;
        f.slot          = s;
        f.last          = 1'b0;
        frames_due.push_back(f);
    endfunction

    function automatic void predict_frames(swarq_pkg::t_in x);
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] hit;
        logic              found;
        int                lim;
        int                n0;
        n0 = frames_due.size();
        case (x.command)
            swarq_pkg::CMD_SEND: begin
                s = free_slot[x.receiver] + 3'd1;
                if (s == oldest[x.receiver]) begin
                    push_frame(swarq_pkg::KIND_REJECT, x.receiver, '0, '0);
                end else begin
                    s = free_slot[x.receiver];
                    slot_seq[x.receiver][s] = next_seq[x.receiver];
                    slot_tmr[x.receiver][s] = timeout_reg;
                    push_frame(swarq_pkg::KIND_NEW, x.receiver, next_seq[x.receiver], s);
                    free_slot[x.receiver] = s + 3'd1;
                    next_seq[x.receiver]  = next_seq[x.receiver] + 4'd1;
                end
            end
            swarq_pkg::CMD_ACK, swarq_pkg::CMD_NAK: begin
                if (x.crc_ok && x.frame_dest == id_reg) begin
                    s = oldest[x.receiver];
                    found = 1'b0;
                    hit = '0;
                    while (!found && s != free_slot[x.receiver]) begin
                        if (slot_seq[x.receiver][s] == x.ack_number) begin
                            found = 1'b1;
                            hit = s;
                        end
                        s = s + 3'd1;
                    end
                    if (found && x.command == swarq_pkg::CMD_ACK) begin
                        oldest[x.receiver] = hit + 3'd1;
                    end else if (found) begin
                        for (s = hit; s != free_slot[x.receiver]; s = s + 3'd1)
                            push_frame(swarq_pkg::KIND_RETX, x.receiver,
                                       slot_seq[x.receiver][s], s);
                    end
                end
            end
            default: begin
                lim = (active_reg > RECEIVERS) ? RECEIVERS : active_reg;
                for (int r = 0; r < lim; r++) begin
                    for (s = oldest[r]; s != free_slot[r]; s = s + 3'd1) begin
                        if (slot_tmr[r][s] <= 1) begin
                            push_frame(swarq_pkg::KIND_RETX, RCV_W'(r), slot_seq[r][s], s);
                            slot_tmr[r][s] = timeout_reg;
                        end else begin
                            slot_tmr[r][s] = slot_tmr[r][s] - 1'b1;
                        end
                    end
                end
            end
        endcase
        if (frames_due.size() > n0)
            frames_due[$].last = 1'b1;
    endfunction

    function automatic swarq_pkg::t_in mk_item(logic [1:0] cmd, logic [RCV_W-1:0] r,
                                               logic [7:0] dest, logic [SEQ_W-1:0] ackn,
                                               logic crc);
        swarq_pkg::t_in x;
        x.command    = cmd;
        x.receiver   = r;
        x.frame_dest = dest;
        x.ack_number = ackn;
        x.crc_ok     = crc;
        return x;
    endfunction

    function automatic t_dir_row mk_row(swarq_pkg::t_in x, logic typed, logic [1:0] kind,
                                        logic [RCV_W-1:0] r);
        t_dir_row row;
        row.item                 = x;
        row.typed                = typed;
        row.result.kind          = kind;
        row.result.dest_receiver = r;
        row.result.seq_num       = '0;
        row.result.slot          = '0;
        row.result.last          = 1'b1;
        return row;
    endfunction

    // random items of every command; acks/naks are mostly well-formed and name a frame still in the window
    function automatic swarq_pkg::t_in rand_item();
        swarq_pkg::t_in    x;
        int                pick;
        logic [SLOT_W-1:0] cnt;
        x = swarq_pkg::t_in'(IN_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 35)      x.command = swarq_pkg::CMD_SEND;
        else if (pick < 55) x.command = swarq_pkg::CMD_ACK;
        else if (pick < 70) x.command = swarq_pkg::CMD_NAK;
        else                x.command = swarq_pkg::CMD_TICK;
        if ((x.command == swarq_pkg::CMD_ACK || x.command == swarq_pkg::CMD_NAK)
                && $urandom_range(0, 99) < 85) begin
            x.frame_dest = id_reg;
            x.crc_ok = 1'b1;
            cnt = free_slot[x.receiver] - oldest[x.receiver];
            if (cnt != 0)
                x.ack_number = slot_seq[x.receiver][oldest[x.receiver]
                               + 3'($urandom_range(0, cnt - 1))];
        end
        return x;
    endfunction

    task automatic send_item(swarq_pkg::t_in x, logic typed, swarq_pkg::t_out typed_result);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        do @(posedge i_clk); while (!in_ready);
        predict_frames(x);
        if (typed) begin
            // table value stands in for the predicted one
            void'(frames_due.pop_back());
            frames_due.push_back(typed_result);
        end
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [7:0] id, logic [LIM_W-1:0] act, logic [TMR_W-1:0] tmo);
        cfg_we <= 1'b1; cfg_idx <= swarq_pkg::REG_SENDER_ID; cfg_data <= CFG_W'(id);
        @(posedge i_clk);
        cfg_idx <= swarq_pkg::REG_ACTIVE; cfg_data <= CFG_W'(act);
        @(posedge i_clk);
        cfg_idx <= swarq_pkg::REG_TIMEOUT; cfg_data <= tmo;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        id_reg = id; active_reg = act; timeout_reg = tmo;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++)
            send_item(rand_item(), 1'b0, '0);
    endtask

    // result side: random stalls, compare in order
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            results_seen++;
            if (out_data.kind == swarq_pkg::KIND_RETX) retx_seen++;
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %p", out_data);
            end else begin
                if (out_data.kind != frames_due[0].kind
                        || out_data.dest_receiver != frames_due[0].dest_receiver
                        || out_data.seq_num != frames_due[0].seq_num
                        || out_data.slot != frames_due[0].slot
                        || out_data.last != frames_due[0].last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", frames_due[0], out_data);
                end
                void'(frames_due.pop_front());
            end
        end
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        idle_pct   = 10;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        retx_seen  = 0;
        stall_cnt  = 0;
        id_reg     = '0;
        active_reg = swarq_pkg::DEFAULT_ACTIVE;
        timeout_reg = swarq_pkg::DEFAULT_TIMEOUT;
        for (int r = 0; r < RECEIVERS; r++) begin
            oldest[r] = '0; free_slot[r] = '0; next_seq[r] = '0;
        end

        dir_rows[0]  = mk_row(mk_item(swarq_pkg::CMD_SEND, 2'd0, 8'h00, 4'd0, 1'b0),
                              1'b1, swarq_pkg::KIND_NEW, 2'd0);
        for (int k = 1; k < 7; k++)
            dir_rows[k] = mk_row(mk_item(swarq_pkg::CMD_SEND, 2'd0, 8'hFF, 4'hF, 1'b1),
                                 1'b0, swarq_pkg::KIND_NEW, 2'd0);
        dir_rows[7]  = mk_row(mk_item(swarq_pkg::CMD_SEND, 2'd0, 8'h00, 4'd0, 1'b0),
                              1'b1, swarq_pkg::KIND_REJECT, 2'd0);
        dir_rows[8]  = mk_row(mk_item(swarq_pkg::CMD_NAK, 2'd0, 8'h00, 4'd3, 1'b1),
                              1'b0, swarq_pkg::KIND_RETX, 2'd0);
        dir_rows[9]  = mk_row(mk_item(swarq_pkg::CMD_NAK, 2'd0, 8'h00, 4'd3, 1'b0),
                              1'b0, swarq_pkg::KIND_RETX, 2'd0);
        dir_rows[10] = mk_row(mk_item(swarq_pkg::CMD_ACK, 2'd0, 8'hFF, 4'hF, 1'b1),
                              1'b0, swarq_pkg::KIND_RETX, 2'd0);
        dir_rows[11] = mk_row(mk_item(swarq_pkg::CMD_ACK, 2'd0, 8'h00, 4'd9, 1'b1),
                              1'b0, swarq_pkg::KIND_RETX, 2'd0);
        dir_rows[12] = mk_row(mk_item(swarq_pkg::CMD_ACK, 2'd0, 8'h00, 4'd2, 1'b1),
                              1'b0, swarq_pkg::KIND_RETX, 2'd0);
        dir_rows[13] = mk_row(mk_item(swarq_pkg::CMD_SEND, 2'd3, 8'h00, 4'd0, 1'b0),
                              1'b1, swarq_pkg::KIND_NEW, 2'd3);
        dir_rows[14] = mk_row(mk_item(swarq_pkg::CMD_TICK, 2'd0, 8'h00, 4'd0, 1'b0),
                              1'b0, swarq_pkg::KIND_RETX, 2'd0);
        dir_rows[15] = mk_row(mk_item(swarq_pkg::CMD_NAK, 2'd0, 8'h00, 4'd6, 1'b1),
                              1'b0, swarq_pkg::KIND_RETX, 2'd0);
        dir_rows[16] = mk_row(mk_item(swarq_pkg::CMD_ACK, 2'd0, 8'h00, 4'd6, 1'b1),
                              1'b0, swarq_pkg::KIND_RETX, 2'd0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset first
        for (int k = 0; k < N_DIRECTED; k++)
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].result);
        drain();

        // every tick expires every frame of receiver 0, the only active one
        write_regs(8'hFF, 3'd1, 16'd1);
        random_phase(N_RANDOM);
        drain();

        // frames never time out; no idling on either side
        idle_pct = 0;
        write_regs(8'($urandom), 3'd2, 16'hFFFF);
        random_phase(N_RANDOM);
        drain();
        idle_pct = 10;

        write_regs(8'($urandom), 3'd4, 16'($urandom_range(2, 6)));
        random_phase(N_RANDOM / 2);
        drain();
        random_phase(N_RANDOM / 2);
        drain();

        write_regs(8'h00, 3'd3, 16'd3);
        random_phase(N_RANDOM);
        drain();

        $display("%0d command items, %0d result items (%0d retransmits) over 5 settings",
                 items_sent, results_seen, retx_seen);
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/swarq_pkg.sv
sv/swarq_ctrl.sv
sv/swarq_dp.sv
sv/sliding_window_arq_sender.sv
bench/sliding_window_arq_sender_tb.sv
